>>> rtl/core/tmq_pkg.sv
`timescale 1ns / 1ps

package tmq_pkg;

   // Field widths of the request and response words
   localparam int CMD_W  = 2;
   localparam int SLOT_W = 4;
   localparam int TIME_W = 64;

   // Default number of event slots
   localparam int EVENT_SLOTS_DEF = 16;

   // Slot range check is done at this width (covers up to 511 slots)
   localparam int SLOT_CMP_W = 9;

   // Events dispatched per tick at most
   localparam int RESULT_CAP = 16;
   localparam int CAP_W      = $clog2(RESULT_CAP + 1);

   // Commands
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

   // Status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   // Write strobes from the sequencer to the storage
   typedef struct packed {
      logic ord_we;
      logic dl_we;
      logic ivl_we;
      logic q_set;
      logic q_clr;
   } tmq_wr_type;

   // One response word
   typedef struct packed {
      logic              status;
      logic              fired;
      logic [SLOT_W-1:0] fired_slot;
      logic              last;
   } tmq_word_type;

endpackage

>>> rtl/core/tmq_chan_if.sv
`timescale 1ns / 1ps

interface tmq_req_if;
   logic                        valid;
   logic                        ready;
   logic [tmq_pkg::CMD_W-1:0]   command;
   logic [tmq_pkg::SLOT_W-1:0]  event_slot;
   logic [tmq_pkg::TIME_W-1:0]  timeout_us;
   logic [tmq_pkg::TIME_W-1:0]  now_us;

   modport source (output valid, output command, output event_slot, output timeout_us,
                   output now_us, input ready);
   modport sink   (input valid, input command, input event_slot, input timeout_us,
                   input now_us, output ready);
endinterface

interface tmq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        status;
   logic                        fired;
   logic [tmq_pkg::SLOT_W-1:0]  fired_slot;
   logic                        last;

   modport source (output valid, output status, output fired, output fired_slot,
                   output last, input ready);
   modport sink   (input valid, input status, input fired, input fired_slot,
                   input last, output ready);
endinterface

>>> rtl/core/tmq_alu.sv
`timescale 1ns / 1ps

module tmq_alu (
   input  logic                        use_now,
   input  logic [tmq_pkg::TIME_W-1:0]  now_val,
   input  logic [tmq_pkg::TIME_W-1:0]  new_deadline,
   input  logic [tmq_pkg::TIME_W-1:0]  timeout_val,
   input  logic [tmq_pkg::TIME_W-1:0]  stored_deadline,
   output logic [tmq_pkg::TIME_W-1:0]  sum,
   output logic                        lt
);

   logic [tmq_pkg::TIME_W-1:0] cmp_a;

   // Deadline of a new entry, wrapping modulo 2^64
   assign sum = now_val + timeout_val;

   // Shared compare: current time on a tick, new deadline on an insert
   assign cmp_a = use_now ? now_val : new_deadline;
   assign lt    = cmp_a < stored_deadline;

endmodule

>>> rtl/core/tmq_store.sv
`timescale 1ns / 1ps

module tmq_store #(
   parameter  int EVENT_SLOTS = tmq_pkg::EVENT_SLOTS_DEF,
   localparam int SW          = $clog2(EVENT_SLOTS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tmq_pkg::tmq_wr_type         wr,
   input  logic [SW-1:0]               tgt,
   input  logic [SW-1:0]               ord_raddr,
   input  logic [SW-1:0]               ord_waddr,
   input  logic [SW-1:0]               ord_wdata,
   input  logic [tmq_pkg::TIME_W-1:0]  dl_wdata,
   input  logic [tmq_pkg::TIME_W-1:0]  ivl_wdata,
   output logic [SW-1:0]               ord_q,
   output logic [tmq_pkg::TIME_W-1:0]  dl_q,
   output logic [tmq_pkg::TIME_W-1:0]  ivl_q,
   output logic                        queued_tgt
);

   logic [SW-1:0]               ord_mem [EVENT_SLOTS];
   logic [tmq_pkg::TIME_W-1:0]  dl_mem  [EVENT_SLOTS];
   logic [tmq_pkg::TIME_W-1:0]  ivl_mem [EVENT_SLOTS];

   logic [SW-1:0]               ord_rd_ff;
   logic [tmq_pkg::TIME_W-1:0]  dl_rd_ff;
   logic [tmq_pkg::TIME_W-1:0]  ivl_rd_ff;
   logic                        ivl_ok_ff;

   logic [EVENT_SLOTS-1:0]      queued_ff, queued_in;
   logic [EVENT_SLOTS-1:0]      ivl_vld_ff, ivl_vld_in;

   // Order list: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr.ord_we) begin
         ord_mem[ord_waddr] <= ord_wdata;
      end
      ord_rd_ff <= ord_mem[ord_raddr];
   end

   // Deadlines: looked up by the slot just read from the order list
   always_ff @(posedge clock) begin
      if (wr.dl_we) begin
         dl_mem[tgt] <= dl_wdata;
      end
      dl_rd_ff <= dl_mem[ord_rd_ff];
   end

   // Intervals: read and written at the target slot
   always_ff @(posedge clock) begin
      if (wr.ivl_we) begin
         ivl_mem[tgt] <= ivl_wdata;
      end
      ivl_rd_ff <= ivl_mem[tgt];
      ivl_ok_ff <= ivl_vld_ff[tgt];
   end

   // Queued flags and interval valid bits
   always_comb begin
      queued_in  = queued_ff;
      ivl_vld_in = ivl_vld_ff;
      if (wr.q_set) begin
         queued_in[tgt] = 1'b1;
      end
      if (wr.q_clr) begin
         queued_in[tgt] = 1'b0;
      end
      if (wr.ivl_we) begin
         ivl_vld_in[tgt] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff  <= '0;
         ivl_vld_ff <= '0;
      end else begin
         queued_ff  <= queued_in;
         ivl_vld_ff <= ivl_vld_in;
      end
   end

   assign ord_q      = ord_rd_ff;
   assign dl_q       = dl_rd_ff;
   assign ivl_q      = ivl_ok_ff ? ivl_rd_ff : '0;
   assign queued_tgt = queued_ff[tgt];

endmodule

>>> rtl/core/tmq_seq.sv
`timescale 1ns / 1ps

module tmq_seq #(
   parameter  int EVENT_SLOTS = tmq_pkg::EVENT_SLOTS_DEF,
   localparam int SW          = $clog2(EVENT_SLOTS)
) (
   input  logic                        clock,
   input  logic                        reset,
   tmq_req_if.sink                     req_chan,
   output tmq_pkg::tmq_wr_type         wr,
   output logic [SW-1:0]               tgt,
   output logic [SW-1:0]               ord_raddr,
   output logic [SW-1:0]               ord_waddr,
   output logic [SW-1:0]               ord_wdata,
   output logic [tmq_pkg::TIME_W-1:0]  dl_wdata,
   output logic [tmq_pkg::TIME_W-1:0]  ivl_wdata,
   input  logic [SW-1:0]               ord_q,
   input  logic [tmq_pkg::TIME_W-1:0]  dl_q,
   input  logic [tmq_pkg::TIME_W-1:0]  ivl_q,
   input  logic                        queued_tgt,
   input  logic                        out_free,
   output logic                        out_load,
   output tmq_pkg::tmq_word_type       out_word
);

   localparam int LW   = $clog2(EVENT_SLOTS + 1);
   localparam int ST_W = 5;

   localparam logic [ST_W-1:0] S_IDLE     = 5'd0;
   localparam logic [ST_W-1:0] S_IVL_WAIT = 5'd1;
   localparam logic [ST_W-1:0] S_IVL_CHK  = 5'd2;
   localparam logic [ST_W-1:0] S_UL_START = 5'd3;
   localparam logic [ST_W-1:0] S_UL_RD    = 5'd4;
   localparam logic [ST_W-1:0] S_UL_DATA  = 5'd5;
   localparam logic [ST_W-1:0] S_UL_END   = 5'd6;
   localparam logic [ST_W-1:0] S_UL_NEXT  = 5'd7;
   localparam logic [ST_W-1:0] S_INS_SET  = 5'd8;
   localparam logic [ST_W-1:0] S_INS_RD   = 5'd9;
   localparam logic [ST_W-1:0] S_INS_DL   = 5'd10;
   localparam logic [ST_W-1:0] S_INS_CMP  = 5'd11;
   localparam logic [ST_W-1:0] S_INS_END  = 5'd12;
   localparam logic [ST_W-1:0] S_TK_RD    = 5'd13;
   localparam logic [ST_W-1:0] S_TK_HD    = 5'd14;
   localparam logic [ST_W-1:0] S_TK_CMP   = 5'd15;
   localparam logic [ST_W-1:0] S_EMIT     = 5'd16;

   logic [ST_W-1:0]                 state_ff, state_in;
   logic [ST_W-1:0]                 nxt_ff, nxt_in;
   logic [tmq_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [SW-1:0]                   tgt_ff, tgt_in;
   logic [tmq_pkg::TIME_W-1:0]      timeout_ff, timeout_in;
   logic [tmq_pkg::TIME_W-1:0]      now_ff, now_in;
   logic [tmq_pkg::TIME_W-1:0]      dl_ff, dl_in;
   logic [LW-1:0]                   len_ff, len_in;
   logic [LW-1:0]                   idx_ff, idx_in;
   logic [LW-1:0]                   idx_dec;
   logic                            found_ff, found_in;
   logic                            refused_ff, refused_in;
   logic [SW-1:0]                   entry_ff, entry_in;
   logic [SW-1:0]                   head_ff, head_in;
   logic [tmq_pkg::CAP_W-1:0]       k_ff, k_in;
   logic                            pend_ff, pend_in;
   logic [SW-1:0]                   pend_slot_ff, pend_slot_in;
   tmq_pkg::tmq_word_type           obuf_ff, obuf_in;

   logic                            in_range;
   logic                            is_tick;
   logic [tmq_pkg::TIME_W-1:0]      sum;
   logic                            lt;

   assign is_tick  = (cmd_ff == tmq_pkg::CMD_TICK);
   assign idx_dec  = idx_ff - LW'(1);
   assign in_range = tmq_pkg::SLOT_CMP_W'(req_chan.event_slot)
                     < tmq_pkg::SLOT_CMP_W'(EVENT_SLOTS);

   // Shared adder and comparator
   tmq_alu u_alu (
      .use_now         (is_tick),
      .now_val         (now_ff),
      .new_deadline    (dl_ff),
      .timeout_val     (timeout_ff),
      .stored_deadline (dl_q),
      .sum             (sum),
      .lt              (lt)
   );

   assign tgt       = tgt_ff;
   assign dl_wdata  = sum;
   assign ivl_wdata = timeout_ff;
   assign out_word  = obuf_ff;
   assign req_chan.ready = (state_ff == S_IDLE);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      nxt_in       = nxt_ff;
      cmd_in       = cmd_ff;
      tgt_in       = tgt_ff;
      timeout_in   = timeout_ff;
      now_in       = now_ff;
      dl_in        = dl_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      refused_in   = refused_ff;
      entry_in     = entry_ff;
      head_in      = head_ff;
      k_in         = k_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      obuf_in      = obuf_ff;
      wr           = '0;
      ord_raddr    = '0;
      ord_waddr    = '0;
      ord_wdata    = '0;
      out_load     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // Take a new word and pick the command path
            if (req_chan.valid) begin
               cmd_in             = req_chan.command;
               tgt_in             = SW'(req_chan.event_slot);
               timeout_in         = req_chan.timeout_us;
               now_in             = req_chan.now_us;
               refused_in         = 1'b0;
               k_in               = '0;
               pend_in            = 1'b0;
               obuf_in.status     = tmq_pkg::STATUS_OK;
               obuf_in.fired      = 1'b0;
               obuf_in.fired_slot = '0;
               obuf_in.last       = 1'b1;
               nxt_in             = S_IDLE;
               state_in           = S_EMIT;
               case (req_chan.command)
                  tmq_pkg::CMD_ADD: begin
                     if (in_range) begin
                        state_in = S_UL_START;
                     end
                  end
                  tmq_pkg::CMD_READD: begin
                     if (in_range) begin
                        state_in = (req_chan.timeout_us == '0) ? S_IVL_WAIT : S_UL_START;
                     end
                  end
                  tmq_pkg::CMD_TICK: begin
                     state_in = S_TK_RD;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end

         S_IVL_WAIT: begin
            state_in = S_IVL_CHK;
         end

         S_IVL_CHK: begin
            // Reuse the stored interval, refuse if there is none
            if (ivl_q == '0) begin
               refused_in = 1'b1;
            end else begin
               timeout_in = ivl_q;
            end
            state_in = S_UL_START;
         end

         S_UL_START: begin
            idx_in   = '0;
            found_in = 1'b0;
            state_in = queued_tgt ? S_UL_RD : S_UL_NEXT;
         end

         S_UL_RD: begin
            ord_raddr = idx_ff[SW-1:0];
            state_in  = S_UL_DATA;
         end

         S_UL_DATA: begin
            // Close the gap left by the target
            if (found_ff) begin
               wr.ord_we = 1'b1;
               ord_waddr = idx_dec[SW-1:0];
               ord_wdata = ord_q;
            end
            found_in = found_ff | (ord_q == tgt_ff);
            if (idx_ff + LW'(1) == len_ff) begin
               state_in = S_UL_END;
            end else begin
               idx_in   = idx_ff + LW'(1);
               state_in = S_UL_RD;
            end
         end

         S_UL_END: begin
            len_in   = len_ff - LW'(1);
            wr.q_clr = 1'b1;
            state_in = S_UL_NEXT;
         end

         S_UL_NEXT: begin
            if (is_tick) begin
               pend_in      = 1'b1;
               pend_slot_in = tgt_ff;
               k_in         = k_ff + tmq_pkg::CAP_W'(1);
               state_in     = S_TK_RD;
            end else if (refused_ff) begin
               obuf_in.status = tmq_pkg::STATUS_REFUSED;
               nxt_in         = S_IDLE;
               state_in       = S_EMIT;
            end else begin
               state_in = S_INS_SET;
            end
         end

         S_INS_SET: begin
            // Store interval and deadline, start the walk from the tail
            wr.dl_we  = 1'b1;
            wr.ivl_we = 1'b1;
            dl_in     = sum;
            idx_in    = len_ff;
            state_in  = S_INS_RD;
         end

         S_INS_RD: begin
            if (idx_ff == '0) begin
               wr.ord_we = 1'b1;
               ord_waddr = '0;
               ord_wdata = tgt_ff;
               state_in  = S_INS_END;
            end else begin
               ord_raddr = idx_dec[SW-1:0];
               state_in  = S_INS_DL;
            end
         end

         S_INS_DL: begin
            entry_in = ord_q;
            state_in = S_INS_CMP;
         end

         S_INS_CMP: begin
            // Shift a later entry up, or drop the target in place
            wr.ord_we = 1'b1;
            ord_waddr = idx_ff[SW-1:0];
            if (lt) begin
               ord_wdata = entry_ff;
               idx_in    = idx_dec;
               state_in  = S_INS_RD;
            end else begin
               ord_wdata = tgt_ff;
               state_in  = S_INS_END;
            end
         end

         S_INS_END: begin
            len_in   = len_ff + LW'(1);
            wr.q_set = 1'b1;
            nxt_in   = S_IDLE;
            state_in = S_EMIT;
         end

         S_TK_RD: begin
            if (len_ff == '0 || k_ff == tmq_pkg::CAP_W'(tmq_pkg::RESULT_CAP)) begin
               obuf_in.fired      = pend_ff;
               obuf_in.fired_slot = pend_ff ? tmq_pkg::SLOT_W'(pend_slot_ff) : '0;
               obuf_in.last       = 1'b1;
               nxt_in             = S_IDLE;
               state_in           = S_EMIT;
            end else begin
               ord_raddr = '0;
               state_in  = S_TK_HD;
            end
         end

         S_TK_HD: begin
            head_in  = ord_q;
            state_in = S_TK_CMP;
         end

         S_TK_CMP: begin
            if (lt) begin
               // Head not yet due: close the tick
               obuf_in.fired      = pend_ff;
               obuf_in.fired_slot = pend_ff ? tmq_pkg::SLOT_W'(pend_slot_ff) : '0;
               obuf_in.last       = 1'b1;
               nxt_in             = S_IDLE;
               state_in           = S_EMIT;
            end else begin
               // Head expired: flush the earlier one, then unlink this one
               tgt_in = head_ff;
               if (pend_ff) begin
                  obuf_in.fired      = 1'b1;
                  obuf_in.fired_slot = tmq_pkg::SLOT_W'(pend_slot_ff);
                  obuf_in.last       = 1'b0;
                  nxt_in             = S_UL_START;
                  state_in           = S_EMIT;
               end else begin
                  state_in = S_UL_START;
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = nxt_ff;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
         k_ff     <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         k_ff     <= k_in;
         pend_ff  <= pend_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      nxt_ff       <= nxt_in;
      cmd_ff       <= cmd_in;
      tgt_ff       <= tgt_in;
      timeout_ff   <= timeout_in;
      now_ff       <= now_in;
      dl_ff        <= dl_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      refused_ff   <= refused_in;
      entry_ff     <= entry_in;
      head_ff      <= head_in;
      pend_slot_ff <= pend_slot_in;
      obuf_ff      <= obuf_in;
   end

   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(EVENT_SLOTS))
      else $error("queue length above slot count");

   a_cap_bound : assert property (@(posedge clock) disable iff (reset)
      k_ff <= tmq_pkg::CAP_W'(tmq_pkg::RESULT_CAP))
      else $error("tick dispatch count above cap");

   a_unlink_len : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UL_END) |=> (len_ff == $past(len_ff) - LW'(1)))
      else $error("unlink did not shorten the queue");

   a_insert_room : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_END) |-> (len_ff < LW'(EVENT_SLOTS)))
      else $error("insert into a full queue");

   a_mid_word_tick : assert property (@(posedge clock) disable iff (reset)
      (out_load && !out_word.last) |-> (is_tick && out_word.fired))
      else $error("non-final word outside a tick dispatch");

endmodule

>>> rtl/core/timer_event_queue.sv
`timescale 1ns / 1ps
// Add / re-add: unlink the slot first if it was queued (the unlink walks the whole list),
// then insert from the tail, shifting later entries up; a zero re-add reuses the interval.
// Tick: check the head against the current time and unlink each expired head, with a word
// per dispatched event and a last word; the single-port order list walk sets the pace.
// One word in flight at a time; the response register lets the next word in early.
// Synchronous reset empties the queue and clears queued and interval-valid flags at once.

module timer_event_queue #(
   parameter int EVENT_SLOTS = tmq_pkg::EVENT_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tmq_req_if.sink     req_chan,
   tmq_rsp_if.source   rsp_chan
);

   localparam int SW = $clog2(EVENT_SLOTS);

   tmq_pkg::tmq_wr_type         wr;
   logic [SW-1:0]               tgt;
   logic [SW-1:0]               ord_raddr;
   logic [SW-1:0]               ord_waddr;
   logic [SW-1:0]               ord_wdata;
   logic [tmq_pkg::TIME_W-1:0]  dl_wdata;
   logic [tmq_pkg::TIME_W-1:0]  ivl_wdata;
   logic [SW-1:0]               ord_q;
   logic [tmq_pkg::TIME_W-1:0]  dl_q;
   logic [tmq_pkg::TIME_W-1:0]  ivl_q;
   logic                        queued_tgt;
   logic                        out_free;
   logic                        out_load;
   tmq_pkg::tmq_word_type       out_word;

   logic                        rsp_valid_ff, rsp_valid_in;
   tmq_pkg::tmq_word_type       rsp_word_ff, rsp_word_in;

   tmq_seq #(
      .EVENT_SLOTS (EVENT_SLOTS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .wr         (wr),
      .tgt        (tgt),
      .ord_raddr  (ord_raddr),
      .ord_waddr  (ord_waddr),
      .ord_wdata  (ord_wdata),
      .dl_wdata   (dl_wdata),
      .ivl_wdata  (ivl_wdata),
      .ord_q      (ord_q),
      .dl_q       (dl_q),
      .ivl_q      (ivl_q),
      .queued_tgt (queued_tgt),
      .out_free   (out_free),
      .out_load   (out_load),
      .out_word   (out_word)
   );

   tmq_store #(
      .EVENT_SLOTS (EVENT_SLOTS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .tgt        (tgt),
      .ord_raddr  (ord_raddr),
      .ord_waddr  (ord_waddr),
      .ord_wdata  (ord_wdata),
      .dl_wdata   (dl_wdata),
      .ivl_wdata  (ivl_wdata),
      .ord_q      (ord_q),
      .dl_q       (dl_q),
      .ivl_q      (ivl_q),
      .queued_tgt (queued_tgt)
   );

   // Response register: load a new word once the held one is taken
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = out_word;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_word_ff.status;
   assign rsp_chan.fired      = rsp_word_ff.fired;
   assign rsp_chan.fired_slot = rsp_word_ff.fired_slot;
   assign rsp_chan.last       = rsp_word_ff.last;

endmodule
